// ----- hw/rtl/chacha_pkg.sv -----
// Package for the ChaCha20 stream cipher: constants, types and the quarter round.
// Used by every module under hw/rtl.
package chacha_pkg;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int RoundCnt = 2 * DOUBLE_ROUNDS;
  localparam int RoundW = $clog2(RoundCnt + 1);
  localparam int QueueDepth = 2;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [2:0] REG_START_COUNTER = 3'd6;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // Item passed from front to back: payload plus the keystream for it.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [63:0] ks;
  } item_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_RUN,
    GEN_DONE
  } gen_state_t;

  function automatic word_t rotl(input word_t v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [127:0] qr(input word_t a_in, input word_t b_in,
                                      input word_t c_in, input word_t d_in);
    word_t a, b, c, d;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qr = {d, c, b, a};
  endfunction
endpackage

// ----- hw/rtl/chacha_core.sv -----
// Keystream block generator: one ChaCha round (four quarter rounds) per cycle.
// Depends on chacha_pkg.
module chacha_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  chacha_pkg::state_t  init,
  output logic                done,
  output chacha_pkg::state_t  block
);
  import chacha_pkg::*;

  state_t            w;
  state_t            init_q;
  state_t            w_next;
  logic [RoundW-1:0] round;
  logic              busy;

  always_comb begin
    logic [127:0] q0, q1, q2, q3;
    w_next = w;
    if (!round[0]) begin
      q0 = qr(w[0], w[4], w[8],  w[12]);
      q1 = qr(w[1], w[5], w[9],  w[13]);
      q2 = qr(w[2], w[6], w[10], w[14]);
      q3 = qr(w[3], w[7], w[11], w[15]);
      {w_next[12], w_next[8],  w_next[4], w_next[0]} = q0;
      {w_next[13], w_next[9],  w_next[5], w_next[1]} = q1;
      {w_next[14], w_next[10], w_next[6], w_next[2]} = q2;
      {w_next[15], w_next[11], w_next[7], w_next[3]} = q3;
    end else begin
      q0 = qr(w[0], w[5], w[10], w[15]);
      q1 = qr(w[1], w[6], w[11], w[12]);
      q2 = qr(w[2], w[7], w[8],  w[13]);
      q3 = qr(w[3], w[4], w[9],  w[14]);
      {w_next[15], w_next[10], w_next[5], w_next[0]} = q0;
      {w_next[12], w_next[11], w_next[6], w_next[1]} = q1;
      {w_next[13], w_next[8],  w_next[7], w_next[2]} = q2;
      {w_next[14], w_next[9],  w_next[4], w_next[3]} = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        if (round == RoundW'(RoundCnt - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        round <= round + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w      <= init;
      init_q <= init;
    end else if (busy) begin
      w <= w_next;
    end
    if (busy && round == RoundW'(RoundCnt - 1)) begin
      for (int i = 0; i < 16; i++) block[i] <= w_next[i] + init_q[i];
    end
  end
endmodule

// ----- hw/rtl/chacha_front.sv -----
// Front end: accepts beats, tracks message position, keeps a block buffered
// and precomputes the next one. Depends on chacha_pkg and chacha_core.
module chacha_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [255:0]        key,
  input  logic [95:0]         nonce,
  input  logic [31:0]         start_counter,
  input  logic                key_touch,
  input  logic                ctr_touch,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_data,
  input  logic [3:0]          in_count,
  input  logic                in_last,
  output logic                q_valid,
  input  logic                q_ready,
  output chacha_pkg::item_t   q_item
);
  import chacha_pkg::*;

  // Current block buffer and one prefetched block for the following counter.
  state_t      cur;
  logic        cur_ok;
  logic        cur_ok_next;
  state_t      nxt;
  logic        nxt_ok;
  logic        nxt_ok_next;
  logic        nxt_busy;
  logic [31:0] cur_ctr;
  logic [2:0]  pos;
  logic [31:0] gen_ctr;
  logic        gen_for_cur;
  logic        gen_stale;
  logic        in_msg;

  logic        core_start;
  state_t      core_init;
  logic        core_done;
  state_t      core_block;
  gen_state_t  gstate;
  gen_state_t  gstate_next;
  logic        take;
  logic        cfg_hit;
  logic        flush;
  logic        flush_all;

  chacha_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .init  (core_init),
    .done  (core_done),
    .block (core_block)
  );

  // The generator runs for the current block when it is missing, otherwise
  // for the block after it. Between messages the first block uses the
  // start counter as it stands when the generator is launched.
  always_comb begin
    gstate_next = gstate;
    core_start  = 1'b0;
    gen_ctr     = cur_ok ? cur_ctr + 32'd1 : (in_msg ? cur_ctr : start_counter);
    case (gstate)
      GEN_IDLE: begin
        if (!cur_ok || !nxt_ok) begin
          core_start  = 1'b1;
          gstate_next = GEN_RUN;
        end
      end
      GEN_RUN: if (core_done) gstate_next = GEN_DONE;
      GEN_DONE: gstate_next = GEN_IDLE;
      default: gstate_next = GEN_IDLE;
    endcase
    core_init[0]  = SIGMA0;
    core_init[1]  = SIGMA1;
    core_init[2]  = SIGMA2;
    core_init[3]  = SIGMA3;
    for (int i = 0; i < 8; i++) core_init[4 + i] = key[32*i +: 32];
    core_init[12] = gen_ctr;
    core_init[13] = nonce[31:0];
    core_init[14] = nonce[63:32];
    core_init[15] = nonce[95:64];
  end

  // The last beat of a message drops both blocks. A key or nonce write drops
  // the prefetched block, and the current one too while none of its beats has
  // been used; a start counter write between messages does the same. A block
  // that was being made from the old values is thrown away when it finishes.
  assign cfg_hit   = key_touch || (ctr_touch && !in_msg);
  assign flush     = (take && in_last) || cfg_hit;
  assign flush_all = (take && in_last) || (cfg_hit && pos == 3'd0);

  assign nxt_busy = (gstate != GEN_IDLE);
  // The eighth beat of a block also needs the next block to be ready.
  assign in_ready = cur_ok && !nxt_busy && (nxt_ok || pos != 3'd7) && (q_ready || !q_valid);
  assign take     = in_valid && in_ready;

  always_comb begin
    cur_ok_next = cur_ok;
    nxt_ok_next = nxt_ok;
    if (gstate == GEN_DONE && !gen_stale) begin
      if (gen_for_cur) cur_ok_next = 1'b1;
      else nxt_ok_next = 1'b1;
    end
    if (take && !in_last && pos == 3'd7) begin
      cur_ok_next = nxt_ok;
      nxt_ok_next = 1'b0;
    end
    if (flush) begin
      nxt_ok_next = 1'b0;
      if (flush_all) cur_ok_next = 1'b0;
    end
  end

  // The output register doubles as the queue entry toward the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate      <= GEN_IDLE;
      cur_ok      <= 1'b0;
      nxt_ok      <= 1'b0;
      pos         <= '0;
      cur_ctr     <= '0;
      q_valid     <= 1'b0;
      gen_for_cur <= 1'b0;
      gen_stale   <= 1'b0;
      in_msg      <= 1'b0;
    end else begin
      gstate <= gstate_next;
      cur_ok <= cur_ok_next;
      nxt_ok <= nxt_ok_next;
      if (core_start) gen_for_cur <= !cur_ok;
      if (gstate == GEN_DONE) gen_stale <= 1'b0;
      else if (flush && (core_start || gstate == GEN_RUN)) gen_stale <= 1'b1;
      if (take) q_valid <= 1'b1;
      else if (q_ready) q_valid <= 1'b0;
      if (take) begin
        in_msg <= !in_last;
        pos    <= in_last ? 3'd0 : pos + 3'd1;
      end
      if (take && !in_last && pos == 3'd7) cur_ctr <= cur_ctr + 32'd1;
      else if (core_start && !cur_ok) cur_ctr <= gen_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (gstate == GEN_DONE && !gen_stale) begin
      if (gen_for_cur) cur <= core_block;
      else nxt <= core_block;
    end
    if (take) begin
      if (pos == 3'd7 && !in_last) cur <= nxt;
      q_item.data  <= in_data;
      q_item.count <= in_count;
      q_item.last  <= in_last;
      q_item.ks    <= {cur[{pos, 1'b1}], cur[{pos, 1'b0}]};
    end
  end
endmodule

// ----- hw/rtl/chacha_back.sv -----
// Back end: XORs data with keystream, masks unused bytes, two-entry skid output.
// Depends on chacha_pkg.
module chacha_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  chacha_pkg::item_t  q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_data,
  output logic [3:0]         out_count,
  output logic               out_last
);
  import chacha_pkg::*;

  logic [QueueDepth-1:0][68:0] fifo;
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;
  logic [63:0]                 mask;
  logic [68:0]                 res;
  logic                        push;
  logic                        pop;

  always_comb begin
    for (int i = 0; i < 8; i++) mask[8*i +: 8] = (q_item.count > 4'(i)) ? 8'hff : 8'h00;
    res = {q_item.last, q_item.count, (q_item.data ^ q_item.ks) & mask};
  end

  assign q_ready   = (fill != 2'd2);
  assign push      = q_valid && q_ready;
  assign out_valid = (fill != 2'd0);
  assign pop       = out_valid && out_ready;
  assign {out_last, out_count, out_data} = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= res;
  end
endmodule

// ----- hw/rtl/chacha20_stream_cipher.sv -----
// ChaCha20 stream cipher top level (32-bit counter, 96-bit nonce).
// An accepted input beat passes through the front end's output register and then the
// back end's FIFO on its way out. Input waits while the round engine makes each block of
// 8 beats, so a message start waits for its first block, and its second beat waits while
// the next block is made.
// Reset (rst, synchronous) clears the configuration, the block valid flags and the queues.
module chacha20_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // data_in [63:0], byte_count [67:64], zeros above
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // data_out [63:0], count_out [67:64], zeros above
  output logic        m_tlast
);
  import chacha_pkg::*;

  // Configuration registers: key as 256 bits, nonce as 96 bits.
  logic [255:0] key;
  logic [95:0]  nonce;
  logic [31:0]  start_counter;

  logic         q_valid;
  logic         q_ready;
  item_t        q_item;
  logic [3:0]   out_count;
  logic         key_touch;
  logic         ctr_touch;

  always_ff @(posedge clk) begin
    if (rst) begin
      key           <= '0;
      nonce         <= '0;
      start_counter <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:          key[63:0]     <= cfg_data;
        REG_KEY1:          key[127:64]   <= cfg_data;
        REG_KEY2:          key[191:128]  <= cfg_data;
        REG_KEY3:          key[255:192]  <= cfg_data;
        REG_NONCE_LOW:     nonce[63:0]   <= cfg_data;
        REG_NONCE_HIGH:    nonce[95:64]  <= cfg_data[31:0];
        REG_START_COUNTER: start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The key and nonce registers sit below the start counter in the index map.
  // The front end uses these strobes to drop keystream made from old values.
  assign key_touch = cfg_we && (cfg_index < REG_START_COUNTER);
  assign ctr_touch = cfg_we && (cfg_index == REG_START_COUNTER);

  // The front end owns block generation and counter tracking; its result
  // register acts as the queue slot handing beats to the back end.
  chacha_front u_front (
    .clk           (clk),
    .rst           (rst),
    .key           (key),
    .nonce         (nonce),
    .start_counter (start_counter),
    .key_touch     (key_touch),
    .ctr_touch     (ctr_touch),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_data       (s_tdata[63:0]),
    .in_count      (s_tdata[67:64]),
    .in_last       (s_tlast),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  chacha_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata[63:0]),
    .out_count (out_count),
    .out_last  (m_tlast)
  );

  assign m_tdata[71:64] = {4'd0, out_count};
endmodule
